[sv/tet_pkg.sv]
package tet_pkg;

	localparam int TIMER_SLOTS_DEF = 64;
	localparam int NOW_W = 48;
	localparam int ID_W = 32;
	localparam int DELAY_W = 32;
	localparam int LIMIT_W = 7;

	localparam logic CMD_ARM = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic KIND_ARM = 1'b0;
	localparam logic KIND_FIRED = 1'b1;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_IGNORED = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	// A classified command as it travels from the front part to the back part.
	typedef struct packed {
		logic tick;
		logic ignore;
		logic [DELAY_W-2:0] delay;
		logic [ID_W-1:0] id;
	} op_t;

	typedef struct packed {
		logic kind;
		logic [1:0] status;
		logic [ID_W-1:0] id;
		logic last;
	} res_t;

	typedef enum logic [2:0] {
		E_IDLE,
		E_RD,
		E_CHK,
		E_MOVE,
		E_FLUSH
	} exec_state_t;

endpackage

[sv/tet_front.sv]
module tet_front import tet_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic cmd,
	input logic signed [DELAY_W-1:0] delay_ms,
	input logic [ID_W-1:0] waiter_id,
	output logic op_valid,
	output op_t op,
	input logic op_take
);

	// Two-entry queue of classified commands.
	op_t mem_q [2];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;
	op_t cls;

	always_comb begin
		cls.tick = (cmd == CMD_TICK);
		cls.ignore = (delay_ms <= 0);
		cls.delay = delay_ms[DELAY_W-2:0];
		cls.id = waiter_id;
	end

	assign full = (cnt_q == 2'd2);
	assign op_valid = (cnt_q != 2'd0);
	assign op = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) wr_q <= ~wr_q;
			if (op_take) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push && !full} - {1'b0, op_take};
		end
	end

endmodule

[sv/tet_exec.sv]
module tet_exec import tet_pkg::*; #(
	parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic [LIMIT_W-1:0] limit,
	input logic op_valid,
	input op_t op,
	output logic op_take,
	output logic res_valid,
	output res_t res,
	input logic res_take
);

	localparam int IW = $clog2(TIMER_SLOTS);
	localparam int CW = $clog2(TIMER_SLOTS + 1);

	logic [NOW_W-1:0] dl_mem [TIMER_SLOTS];
	logic [ID_W-1:0] id_mem [TIMER_SLOTS];

	exec_state_t state_q, state_d;
	logic [NOW_W-1:0] now_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] idx_q;
	logic [NOW_W-1:0] rd_dl_q;
	logic [ID_W-1:0] rd_id_q;
	// A found expiry is held back one beat so that the final one can carry last.
	logic pend_q;
	logic [ID_W-1:0] pend_id_q;
	logic out_v_q;
	res_t out_q;

	logic out_free, expired, scan_more;
	logic [CW-1:0] eff_limit;
	logic [CW-1:0] lastix;
	logic [IW-1:0] rd_addr;

	assign out_free = !out_v_q || res_take;
	assign res_valid = out_v_q;
	assign res = out_q;
	assign eff_limit = (limit > LIMIT_W'(TIMER_SLOTS)) ? CW'(TIMER_SLOTS)
		: CW'(limit);
	assign lastix = cnt_q - 1'b1;
	assign expired = (rd_dl_q <= now_q);
	assign scan_more = (idx_q < cnt_q);
	// On the way into a move the last entry is fetched, so the move writes it from the
	// read register.
	assign rd_addr = (state_d == E_MOVE) ? lastix[IW-1:0] : idx_q[IW-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			E_IDLE: if (op_valid && op.tick) state_d = E_RD;
			E_RD: state_d = scan_more ? E_CHK : E_FLUSH;
			E_CHK: if (!expired) state_d = E_RD;
				else if (!pend_q || out_free) state_d = E_MOVE;
			E_MOVE: state_d = E_RD;
			E_FLUSH: if (!pend_q || out_free) state_d = E_IDLE;
			default: state_d = E_IDLE;
		endcase
	end

	always_comb begin
		op_take = 1'b0;
		if (state_q == E_IDLE && op_valid) begin
			op_take = op.tick || out_free;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == E_IDLE && op_take && !op.tick && !op.ignore
			&& cnt_q < eff_limit) begin
			dl_mem[cnt_q[IW-1:0]] <= now_q + NOW_W'(op.delay);
			id_mem[cnt_q[IW-1:0]] <= op.id;
		end else if (state_q == E_MOVE) begin
			dl_mem[idx_q[IW-1:0]] <= rd_dl_q;
			id_mem[idx_q[IW-1:0]] <= rd_id_q;
		end
		rd_dl_q <= dl_mem[rd_addr];
		rd_id_q <= id_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			now_q <= '0;
			cnt_q <= '0;
			idx_q <= '0;
			pend_q <= 1'b0;
			pend_id_q <= '0;
			out_v_q <= 1'b0;
			out_q <= '0;
		end else begin
			state_q <= state_d;
			if (out_v_q && res_take) out_v_q <= 1'b0;
			unique case (state_q)
				E_IDLE: if (op_take) begin
					if (op.tick) begin
						now_q <= now_q + 1'b1;
						idx_q <= '0;
					end else begin
						out_v_q <= 1'b1;
						out_q.kind <= KIND_ARM;
						out_q.id <= op.id;
						out_q.last <= 1'b1;
						if (op.ignore) out_q.status <= ST_IGNORED;
						else if (cnt_q >= eff_limit) out_q.status <= ST_FULL;
						else begin
							out_q.status <= ST_OK;
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				E_CHK: begin
					if (!expired) idx_q <= idx_q + 1'b1;
					else if (!pend_q || out_free) begin
						if (pend_q) begin
							out_v_q <= 1'b1;
							out_q <= '{KIND_FIRED, ST_OK, pend_id_q, 1'b0};
						end
						pend_q <= 1'b1;
						pend_id_q <= rd_id_q;
					end
				end
				E_MOVE: cnt_q <= lastix;
				E_FLUSH: if (pend_q && out_free) begin
					out_v_q <= 1'b1;
					out_q <= '{KIND_FIRED, ST_OK, pend_id_q, 1'b1};
					pend_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(TIMER_SLOTS)) else $error("armed count over slots");
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == E_CHK) |-> (idx_q < cnt_q)) else $error("scan index beyond count");
	a_no_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == E_IDLE) |-> !pend_q) else $error("held expiry lost");
	a_move_after_chk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == E_MOVE) |-> $past(state_q == E_CHK)) else $error("bad move");

endmodule

[sv/timer_expiry_table.sv]
// Channel  | Handshake         | Ports
// input    | push / full       | cmd, delay_ms, waiter_id
// result   | empty / pop       | kind, status, woken_id, last
// config   | slot_limit_we     | slot_limit_wd (slot_limit)
// An arm's result is registered by the back part when it takes the command from the queue.
// A tick reads and checks each armed entry in turn, moves the last entry into each
// expired slot and then flushes the held expiry; the single read port of the deadline
// table sets its pace.
// Reset clears the counter, the armed count and all queues; stored
// entries stay undefined until armed. A stalled pop holds the scan at the
// next expiry; pushes queue in a two-entry buffer until full rises.
module timer_expiry_table import tet_pkg::*; #(
	parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic cmd,
	input logic signed [DELAY_W-1:0] delay_ms,
	input logic [ID_W-1:0] waiter_id,
	output logic empty,
	input logic pop,
	output logic kind,
	output logic [1:0] status,
	output logic [ID_W-1:0] woken_id,
	output logic last,
	input logic slot_limit_we,
	input logic [LIMIT_W-1:0] slot_limit_wd
);

	logic [LIMIT_W-1:0] limit_q;
	logic op_valid, op_take, res_valid;
	op_t op;
	res_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) limit_q <= LIMIT_W'(64);
		else if (slot_limit_we) limit_q <= slot_limit_wd;
	end

	tet_front u_front (
		.clk, .arst_n, .push, .full, .cmd, .delay_ms, .waiter_id,
		.op_valid, .op, .op_take
	);

	tet_exec #(.TIMER_SLOTS(TIMER_SLOTS)) u_exec (
		.clk, .arst_n, .limit(limit_q), .op_valid, .op, .op_take,
		.res_valid, .res, .res_take(pop && res_valid)
	);

	assign empty = !res_valid;
	assign kind = res.kind;
	assign status = res.status;
	assign woken_id = res.id;
	assign last = res.last;

endmodule

[sim/tet_checker.sv]
module tet_checker import tet_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic full,
	input logic cmd,
	input logic signed [DELAY_W-1:0] delay_ms,
	input logic [ID_W-1:0] waiter_id,
	input logic empty,
	input logic pop,
	input logic kind,
	input logic [1:0] status,
	input logic [ID_W-1:0] woken_id,
	input logic last,
	input logic slot_limit_we,
	input logic [LIMIT_W-1:0] slot_limit_wd,
	output int mismatches,
	output int pending
);
	timeunit 1ns;
	timeprecision 1ps;

	res_t expected_results[$];
	logic [NOW_W-1:0] now_ms;
	logic [NOW_W-1:0] deadlines[TIMER_SLOTS_DEF];
	logic [ID_W-1:0] waiters[TIMER_SLOTS_DEF];
	int armed;
	logic [LIMIT_W-1:0] limit_reg;

	assign pending = expected_results.size();

	task automatic report(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	function automatic res_t make_res(logic k, logic [1:0] s, logic [ID_W-1:0] id, logic l);
		res_t r;
		r.kind = k;
		r.status = s;
		r.id = id;
		r.last = l;
		return r;
	endfunction

	task automatic predict_beat(input logic c, input logic signed [DELAY_W-1:0] d,
			input logic [ID_W-1:0] id);
		int eff_limit;
		int i;
		int fired;
		if (c == CMD_ARM) begin
			eff_limit = (limit_reg > TIMER_SLOTS_DEF) ? TIMER_SLOTS_DEF : int'(limit_reg);
			if (d <= 0) begin
				expected_results.push_back(make_res(KIND_ARM, ST_IGNORED, id, 1'b1));
			end else if (armed >= eff_limit) begin
				expected_results.push_back(make_res(KIND_ARM, ST_FULL, id, 1'b1));
			end else begin
				deadlines[armed] = now_ms + NOW_W'(unsigned'(d));
				waiters[armed] = id;
				armed++;
				expected_results.push_back(make_res(KIND_ARM, ST_OK, id, 1'b1));
			end
		end else begin
			now_ms = now_ms + 1'b1;
			i = 0;
			fired = 0;
			// An expired slot takes the last entry, which is examined in its turn.
			while (i < armed) begin
				if (deadlines[i] <= now_ms) begin
					expected_results.push_back(make_res(KIND_FIRED, ST_OK, waiters[i], 1'b0));
					fired++;
					deadlines[i] = deadlines[armed-1];
					waiters[i] = waiters[armed-1];
					armed--;
				end else begin
					i++;
				end
			end
			if (fired > 0)
				expected_results[$].last = 1'b1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t exp_r;
		if (!arst_n) begin
			expected_results.delete();
			now_ms = '0;
			armed = 0;
			limit_reg = LIMIT_W'(TIMER_SLOTS_DEF);
			mismatches = 0;
		end else begin
			if (!empty && pop) begin
				if (expected_results.size() == 0) begin
					report($sformatf("unexpected beat kind=%0d id=%h", kind, woken_id));
				end else begin
					exp_r = expected_results.pop_front();
					if (kind !== exp_r.kind)
						report($sformatf("kind %0d, want %0d", kind, exp_r.kind));
					if (status !== exp_r.status)
						report($sformatf("status %0d, want %0d", status, exp_r.status));
					if (woken_id !== exp_r.id)
						report($sformatf("woken_id %h, want %h", woken_id, exp_r.id));
					if (last !== exp_r.last)
						report($sformatf("last %0d, want %0d", last, exp_r.last));
				end
			end
			if (push && !full)
				predict_beat(cmd, delay_ms, waiter_id);
			if (slot_limit_we)
				limit_reg = slot_limit_wd;
		end
	end
endmodule

[sim/tb_top.sv]
module tb_top import tet_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic cmd = CMD_ARM;
	logic signed [DELAY_W-1:0] delay_ms = '0;
	logic [ID_W-1:0] waiter_id = '0;
	logic empty;
	logic pop = 1'b0;
	logic kind;
	logic [1:0] status;
	logic [ID_W-1:0] woken_id;
	logic last;
	logic slot_limit_we = 1'b0;
	logic [LIMIT_W-1:0] slot_limit_wd = '0;
	int mismatches;
	int pending;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;

	timer_expiry_table uut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .cmd(cmd),
		.delay_ms(delay_ms), .waiter_id(waiter_id), .empty(empty), .pop(pop),
		.kind(kind), .status(status), .woken_id(woken_id), .last(last),
		.slot_limit_we(slot_limit_we), .slot_limit_wd(slot_limit_wd)
	);

	tet_checker chk (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .cmd(cmd),
		.delay_ms(delay_ms), .waiter_id(waiter_id), .empty(empty), .pop(pop),
		.kind(kind), .status(status), .woken_id(woken_id), .last(last),
		.slot_limit_we(slot_limit_we), .slot_limit_wd(slot_limit_wd),
		.mismatches(mismatches), .pending(pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// The receiver: random stalls, plus a long hold-off whenever one is requested.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			pop <= 1'b0;
		end else if (hold_requests != hold_served) begin
			hold_served <= hold_requests;
			hold_left <= 400;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send_beat(input logic c, input logic signed [DELAY_W-1:0] d,
			input logic [ID_W-1:0] id);
		logic was_full;
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		cmd <= c;
		delay_ms <= d;
		waiter_id <= id;
		do begin
			@(negedge clk);
			was_full = full;
			@(posedge clk);
		end while (was_full);
	endtask

	task automatic arm(input logic signed [DELAY_W-1:0] d, input logic [ID_W-1:0] id);
		send_beat(CMD_ARM, d, id);
	endtask

	task automatic tick();
		send_beat(CMD_TICK, DELAY_W'($urandom), $urandom);
	endtask

	// Waits for the block to drain, including ticks that produce no beat.
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_limit(input logic [LIMIT_W-1:0] v);
		drain();
		slot_limit_we <= 1'b1;
		slot_limit_wd <= v;
		@(posedge clk);
		slot_limit_we <= 1'b0;
	endtask

	task automatic random_beat();
		int r;
		r = $urandom_range(99);
		if (r < 40)
			tick();
		else if (r < 48)
			arm(($urandom_range(1) != 0) ? 32'sd0 : DELAY_W'($urandom | 32'h8000_0000),
				$urandom);
		else if (r < 54)
			arm(DELAY_W'($urandom), $urandom);
		else
			arm(DELAY_W'($urandom_range(30, 1)), $urandom);
	endtask

	task automatic random_phase(input int n_beats);
		repeat (n_beats) random_beat();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, ignored delays, an empty tick, and several
		// expiries in one tick where the last entry is moved into a freed slot.
		arm(32'sd0, 32'h0000_0000);
		arm(32'sh8000_0000, 32'hFFFF_FFFF);
		arm(-32'sd1, 32'h1234_5678);
		tick();
		arm(32'sh7FFF_FFFF, 32'hFFFF_FFFF);
		arm(32'sd1, 32'h0000_0000);
		arm(32'sd5, 32'hAAAA_AAAA);
		arm(32'sd1, 32'h5555_5555);
		arm(32'sd2, 32'h0000_0001);
		tick();
		tick();
		tick();
		tick();

		// A limit lowered below the count keeps entries firing and blocks arms.
		arm(32'sd3, 32'h0000_0011);
		arm(32'sd3, 32'h0000_0022);
		arm(32'sd4, 32'h0000_0033);
		write_limit(7'd1);
		arm(32'sd2, 32'h0000_0044);
		tick();
		tick();
		tick();
		arm(32'sd9, 32'h0000_0055);
		write_limit(7'd0);
		arm(32'sd1, 32'h0000_0066);
		arm(32'sd0, 32'h0000_0077);
		write_limit(7'd127);
		tick();

		random_phase(80);
		write_limit(7'd1);
		send_idle_pct = 70;
		random_phase(80);
		write_limit(7'd8);
		send_idle_pct = 0;
		recv_idle_pct = 70;
		random_phase(80);
		write_limit(7'd0);
		send_idle_pct = 22;
		recv_idle_pct = 22;
		random_phase(30);
		write_limit(7'd64);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_requests = hold_requests + 1;
		random_phase(100);
		write_limit(LIMIT_W'($urandom_range(64, 2)));
		send_idle_pct = 22;
		recv_idle_pct = 22;
		random_phase(110);

		drain();
		if (mismatches == 0 && pending == 0) begin
			$display("[timer_expiry_table] OK");
		end else begin
			$display("[timer_expiry_table] ERROR");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("[timer_expiry_table] ERROR");
		$finish;
	end
endmodule
